// File: hw/rtl/spr_pkg.sv
// Shared types and constants for the servo pulse ramp generator.
package spr_pkg;

   localparam int unsigned ANGLE_W  = 8;
   localparam int unsigned PULSE_W  = 13;
   localparam int unsigned FLEN_W   = 17;
   localparam int unsigned TICK_W   = 21;
   localparam int unsigned GAP_W    = 20;
   localparam int unsigned FRAMES_W = 6;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [ANGLE_W-1:0] MAX_ANGLE = 8'd180;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_MOVE = 1'b1;

   // Scaled reciprocal: angle * 1000 / 90 equals (angle * RECIP_SCALE) >> 16
   // exactly for every angle from 0 to 180.
   localparam logic [19:0] RECIP_SCALE = 20'd728200;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_PERIOD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PULSE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_DEGREES = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_REPEAT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_MS = 3'd4;

   localparam logic [15:0] RST_FRAME_PERIOD = 16'd20000;
   localparam logic [11:0] RST_MIN_PULSE    = 12'd600;
   localparam logic [7:0]  RST_STEP_DEGREES = 8'd3;
   localparam logic [5:0]  RST_FAST_REPEAT  = 6'd50;
   localparam logic [11:0] RST_TICKS_PER_MS = 12'd1000;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_FRAME = 3'b010,
      PH_GAP   = 3'b100
   } phase_type;

   typedef struct packed {
      logic [15:0] frame_period_us;
      logic [11:0] min_pulse_us;
      logic [7:0]  step_degrees;
      logic [5:0]  fast_repeat;
      logic [11:0] ticks_per_ms;
   } cfg_type;

   typedef struct packed {
      logic               kind;
      logic signed [15:0] aim_angle;
      logic               fast_mode;
      logic [7:0]         pause_ms;
   } req_word_type;

   typedef struct packed {
      logic               pin_level;
      logic               busy_res;
      logic [ANGLE_W-1:0] angle_now;
      logic               accepted;
   } rsp_word_type;

endpackage

// File: hw/rtl/spr_if.sv
// Handshake channel interfaces for request and response words.
interface spr_req_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic signed [15:0] aim_angle;
   logic               fast_mode;
   logic [7:0]         pause_ms;

   modport source (output valid, output kind, output aim_angle, output fast_mode,
                   output pause_ms, input ready);
   modport sink   (input valid, input kind, input aim_angle, input fast_mode,
                   input pause_ms, output ready);
endinterface

interface spr_rsp_if;
   logic       valid;
   logic       ready;
   logic       pin_level;
   logic       busy_res;
   logic [7:0] angle_now;
   logic       accepted;

   modport source (output valid, output pin_level, output busy_res, output angle_now,
                   output accepted, input ready);
   modport sink   (input valid, input pin_level, input busy_res, input angle_now,
                   input accepted, output ready);
endinterface

// File: hw/rtl/spr_pulse_calc.sv
// Pulse width and frame length for the angle of the current frame.
module spr_pulse_calc
   import spr_pkg::*;
(
   input  logic [ANGLE_W-1:0] angle,
   input  cfg_type            cfg,
   output logic [PULSE_W-1:0] pulse,
   output logic [FLEN_W-1:0]  frame_len
);

   logic [27:0]          scaled;
   logic [10:0]          offset;
   logic [FLEN_W-1:0]    pulse_ext;
   logic [FLEN_W-1:0]    period_ext;
   logic [FLEN_W-1:0]    longest;

   assign scaled     = 28'(angle) * 28'(RECIP_SCALE);
   assign offset     = scaled[26:16];
   assign pulse      = PULSE_W'(cfg.min_pulse_us) + PULSE_W'(offset);
   assign pulse_ext  = FLEN_W'(pulse);
   assign period_ext = FLEN_W'(cfg.frame_period_us);
   assign longest    = (period_ext > pulse_ext) ? period_ext : pulse_ext;
   assign frame_len  = (longest == '0) ? FLEN_W'(1) : longest;

endmodule

// File: hw/rtl/spr_servo_core.sv
// Move state, frame timing and ramp stepping for one word per cycle while fire is high.
module spr_servo_core
   import spr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_word_type word,
   input  cfg_type      cfg,
   output rsp_word_type result
);

   phase_type             phase_ff, phase_in;
   logic [ANGLE_W-1:0]    position_ff, position_in;
   logic [ANGLE_W-1:0]    ramp_ff, ramp_in;
   logic [ANGLE_W-1:0]    goal_ff, goal_in;
   logic                  moving_up_ff, moving_up_in;
   logic                  jump_ff, jump_in;
   logic [TICK_W-1:0]     tick_ff, tick_in;
   logic [FRAMES_W-1:0]   frames_ff, frames_in;
   logic [7:0]            gap_ff, gap_in;

   logic [PULSE_W-1:0]    pulse;
   logic [FLEN_W-1:0]     frame_len;
   logic [GAP_W-1:0]      gap_len;
   logic [ANGLE_W-1:0]    step;
   logic [ANGLE_W:0]      up_next;
   logic                  step_ok;
   logic [ANGLE_W-1:0]    step_angle;
   logic [TICK_W-1:0]     tick_inc;
   logic [ANGLE_W-1:0]    clamped;
   logic [FRAMES_W-1:0]   frames_dec;
   logic                  busy;
   logic                  busy_after;

   spr_pulse_calc u_pulse (
      .angle     (ramp_ff),
      .cfg       (cfg),
      .pulse     (pulse),
      .frame_len (frame_len)
   );

   assign busy       = (phase_ff != PH_IDLE);
   assign step       = (cfg.step_degrees == '0) ? ANGLE_W'(1) : cfg.step_degrees;
   assign up_next    = {1'b0, ramp_ff} + {1'b0, step};
   assign tick_inc   = tick_ff + TICK_W'(1);
   assign frames_dec = frames_ff - FRAMES_W'(1);
   assign gap_len    = GAP_W'(gap_ff) * GAP_W'(cfg.ticks_per_ms);

   always_comb begin
      if (moving_up_ff) begin
         step_ok    = (up_next <= {1'b0, goal_ff});
         step_angle = up_next[ANGLE_W-1:0];
      end else begin
         step_ok    = (ramp_ff >= step) && ((ramp_ff - step) >= goal_ff);
         step_angle = ramp_ff - step;
      end
   end

   always_comb begin
      if (word.aim_angle[15]) begin
         clamped = '0;
      end else if (word.aim_angle > 16'sd180) begin
         clamped = MAX_ANGLE;
      end else begin
         clamped = word.aim_angle[ANGLE_W-1:0];
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      position_in  = position_ff;
      ramp_in      = ramp_ff;
      goal_in      = goal_ff;
      moving_up_in = moving_up_ff;
      jump_in      = jump_ff;
      tick_in      = tick_ff;
      frames_in    = frames_ff;
      gap_in       = gap_ff;
      result       = '0;
      busy_after   = 1'b0;

      if (word.kind == KIND_MOVE) begin
         if (!busy) begin
            goal_in  = clamped;
            jump_in  = word.fast_mode;
            gap_in   = word.pause_ms;
            tick_in  = '0;
            phase_in = PH_FRAME;
            if (word.fast_mode) begin
               ramp_in      = clamped;
               frames_in    = (cfg.fast_repeat == '0) ? FRAMES_W'(1) : cfg.fast_repeat;
               moving_up_in = 1'b0;
            end else begin
               ramp_in      = position_ff;
               moving_up_in = (clamped > position_ff);
               frames_in    = '0;
            end
            result.accepted = 1'b1;
         end
         busy_after       = (phase_in != PH_IDLE);
         result.busy_res  = busy_after;
         result.angle_now = busy_after ? ramp_in : position_ff;
      end else if (!busy) begin
         result.angle_now = position_ff;
      end else begin
         result.busy_res  = 1'b1;
         result.angle_now = ramp_ff;
         tick_in          = tick_inc;
         if (phase_ff == PH_FRAME) begin
            result.pin_level = (tick_ff < TICK_W'(pulse));
            if (tick_inc >= TICK_W'(frame_len)) begin
               tick_in = '0;
               if (jump_ff) begin
                  frames_in = frames_dec;
                  if (frames_dec == '0) begin
                     position_in = goal_ff;
                     phase_in    = PH_IDLE;
                  end
               end else if (gap_len != '0) begin
                  phase_in = PH_GAP;
               end else if (step_ok) begin
                  ramp_in  = step_angle;
                  phase_in = PH_FRAME;
               end else begin
                  position_in = goal_ff;
                  phase_in    = PH_IDLE;
                  frames_in   = '0;
               end
            end
         end else if (tick_inc >= TICK_W'(gap_len)) begin
            tick_in = '0;
            if (step_ok) begin
               ramp_in  = step_angle;
               phase_in = PH_FRAME;
            end else begin
               position_in = goal_ff;
               phase_in    = PH_IDLE;
               frames_in   = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         position_ff  <= '0;
         ramp_ff      <= '0;
         goal_ff      <= '0;
         moving_up_ff <= 1'b0;
         jump_ff      <= 1'b0;
         tick_ff      <= '0;
         frames_ff    <= '0;
         gap_ff       <= '0;
      end else if (fire) begin
         phase_ff     <= phase_in;
         position_ff  <= position_in;
         ramp_ff      <= ramp_in;
         goal_ff      <= goal_in;
         moving_up_ff <= moving_up_in;
         jump_ff      <= jump_in;
         tick_ff      <= tick_in;
         frames_ff    <= frames_in;
         gap_ff       <= gap_in;
      end
   end

endmodule

// File: hw/rtl/servo_pulse_ramp_generator_top.sv
// Each request word passes the input register and then the response register.
// One request word per cycle while no waiting response stalls the single-pass core.
// An input register and a response register let a new word enter while a result waits.
// Reset clears the move state and the valid flags and loads the config defaults.
// Top level of the servo pulse ramp generator.
module servo_pulse_ramp_generator_top
   import spr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   spr_req_if.sink               req_chan,
   spr_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type      cfg_ff;
   logic         in_valid_ff;
   req_word_type in_word_ff;
   logic         out_valid_ff;
   rsp_word_type out_word_ff;
   rsp_word_type result;
   logic         advance;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_period_us <= RST_FRAME_PERIOD;
         cfg_ff.min_pulse_us    <= RST_MIN_PULSE;
         cfg_ff.step_degrees    <= RST_STEP_DEGREES;
         cfg_ff.fast_repeat     <= RST_FAST_REPEAT;
         cfg_ff.ticks_per_ms    <= RST_TICKS_PER_MS;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_PERIOD: cfg_ff.frame_period_us <= csr_wdata;
            CSR_MIN_PULSE:    cfg_ff.min_pulse_us    <= csr_wdata[11:0];
            CSR_STEP_DEGREES: cfg_ff.step_degrees    <= csr_wdata[7:0];
            CSR_FAST_REPEAT:  cfg_ff.fast_repeat     <= csr_wdata[5:0];
            CSR_TICKS_PER_MS: cfg_ff.ticks_per_ms    <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_word_ff.kind      <= req_chan.kind;
         in_word_ff.aim_angle <= req_chan.aim_angle;
         in_word_ff.fast_mode <= req_chan.fast_mode;
         in_word_ff.pause_ms  <= req_chan.pause_ms;
      end
   end

   spr_servo_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .word   (in_word_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_word_ff <= result;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.pin_level = out_word_ff.pin_level;
   assign rsp_chan.busy_res  = out_word_ff.busy_res;
   assign rsp_chan.angle_now = out_word_ff.angle_now;
   assign rsp_chan.accepted  = out_word_ff.accepted;

endmodule

// File: hw/rtl/spr_checker.sv
// Port-level checks on the response channel of the servo pulse ramp generator.
module spr_checker
   import spr_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_pin_level,
   input logic       rsp_busy_res,
   input logic [7:0] rsp_angle_now,
   input logic       rsp_accepted
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Response word dropped while stalled.");

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Response valid after reset.");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_busy_res && !rsp_pin_level)
      else $error("Accepted command does not start a move.");

   a_pin_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pin_level |-> rsp_busy_res)
      else $error("Pin driven high while idle.");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_angle_now <= MAX_ANGLE)
      else $error("Reported angle beyond range.");

endmodule

bind servo_pulse_ramp_generator_top spr_checker u_spr_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_pin_level (rsp_chan.pin_level),
   .rsp_busy_res  (rsp_chan.busy_res),
   .rsp_angle_now (rsp_chan.angle_now),
   .rsp_accepted  (rsp_chan.accepted)
);
